// ===== src/star_neighbourhood_rgb_blur_macros.svh =====
// assertion macros for the star blur block
`ifndef STAR_NEIGHBOURHOOD_RGB_BLUR_MACROS_SVH
`define STAR_NEIGHBOURHOOD_RGB_BLUR_MACROS_SVH
// implication checked on every clock edge outside reset
`define SNB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// implication checked in the next cycle
`define SNB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/snb_pkg.sv =====
// types and constants shared by the star blur block
package snb_pkg;
  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } snb_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } snb_out_t;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;
  localparam int         MAX_HEIGHT = 4096;
  localparam int         HW         = 13;
endpackage

// ===== src/snb_ram.sv =====
// generic single-port-write, single-read ram with registered read
module snb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/snb_div.sv =====
// restoring divider: 16-bit sum by 10-bit count, one quotient bit per cycle
module snb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [7:0]  quotient
);
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [9:0]  dvs_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [16:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[15]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {7'd0, dvs_r}) begin
        rem_nxt = 16'(trial - {7'd0, dvs_r});
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = busy_r && (cnt_r == 5'd1);
  assign quotient = quo_nxt[7:0];
endmodule

// ===== src/star_neighbourhood_rgb_blur.sv =====
// top level of the star blur: control, row store and averaging
//
// Star-shaped mean blur over an RGB frame that arrives in raster order.
// Input channel in_valid/in_stall/in_data carries pixels (kind 0) or fillers
// (kind 1). Result channel out_valid/out_stall/out_data carries averaged
// pixels; frame_end marks the last one. Configuration writes go over
// cfg_valid/cfg_ready/cfg_index/cfg_data; known indexes restart the frame.
// A pixel item is written into the row store; any item, when an output is due,
// gathers up to 8R+1 samples one memory read per cycle, then divides the
// three sums by the sample count in three bit-serial dividers.
// An item is finished, with or without a result, before the next is accepted.
// The read port of the row store sets the gather length, the bit-serial divider
// the tail.
// Output lags input by radius rows plus radius pixels; fillers flush the rest.
// The result sits in an output register until taken; while it waits no new
// item is accepted. Reset clears counters and restores the register reset
// values; the row store is never cleared and needs no clearing pass.
module star_neighbourhood_rgb_blur #(
  parameter int MAX_RADIUS = 8,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  snb_pkg::snb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output snb_pkg::snb_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data
);
  import snb_pkg::*;
  `include "star_neighbourhood_rgb_blur_macros.svh"

  localparam int RING  = 2 * MAX_RADIUS + 2;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(RING);
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int RADW  = $clog2(MAX_RADIUS + 1);
  localparam int TW    = CW + HW + 1;
  localparam int SCW   = $clog2(8 * MAX_RADIUS + 2);
  localparam int SW    = 8 + SCW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHK   = 3'd1;
  localparam logic [2:0] ST_ADDR  = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;
  localparam logic [2:0] ST_START = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [3:0] rad_r;
  logic [10:0] wid_r;
  logic [12:0] hgt_r;
  logic [CW:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RADW-1:0] r_eff;

  logic [CW:0] icol_r;
  logic [HW-1:0] irow_r;
  logic [CW:0] ocol_r;
  logic [HW-1:0] orow_r;

  // neighbour walk: d from 1..r, k over the eight directions
  logic [RADW-1:0] d_r;
  logic [2:0] k_r;
  logic first_r;
  logic pend_r;
  logic [SW-1:0] sr_r, sg_r, sb_r;
  logic [SCW-1:0] cnt_r;
  snb_out_t res_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0] rdata;

  always_comb begin
    if (wid_r == 11'd0) w_eff = (CW+1)'(1);
    else if ({21'd0, wid_r} > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(wid_r);
    if (hgt_r == 13'd0) h_eff = HW'(1);
    else if ({19'd0, hgt_r} > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = hgt_r;
    if ({28'd0, rad_r} > MAX_RADIUS) r_eff = RADW'(MAX_RADIUS);
    else r_eff = RADW'(rad_r);
  end

  // output readiness (combinational, checked in ST_CHK after an item is accepted)
  logic [TW-1:0] recv, pos, need, total;
  logic [TW+RADW-1:0] need_w;
  logic [TW-1:0] prod_r, prod_w;
  logic ready_out;
  assign total  = TW'(w_eff) * TW'(h_eff);
  assign recv   = TW'(irow_r) * TW'(w_eff) + TW'(icol_r);
  assign pos    = TW'(orow_r) * TW'(w_eff) + TW'(ocol_r);
  assign prod_w = TW'(r_eff) * TW'(w_eff);
  assign need_w = (TW+RADW)'(pos) + (TW+RADW)'(prod_r) + (TW+RADW)'(r_eff) + 1'b1;
  assign need   = (need_w > (TW+RADW)'(total)) ? total : TW'(need_w);
  assign ready_out = (orow_r < h_eff) && (recv >= need);

  // neighbour offset selection
  logic signed [1:0] dy, dx;
  logic valid_n;
  logic [CW:0] nx;
  // ring slot of the output row and of the neighbour row
  logic [RW-1:0] oring_r;
  logic [RW:0] ring_up, ring_dn;
  logic [RW-1:0] ring_c;
  always_comb begin
    unique case (k_r)
      3'd0: begin dy = -2'sd1; dx = -2'sd1; end
      3'd1: begin dy = -2'sd1; dx =  2'sd0; end
      3'd2: begin dy = -2'sd1; dx =  2'sd1; end
      3'd3: begin dy =  2'sd0; dx = -2'sd1; end
      3'd4: begin dy =  2'sd0; dx =  2'sd1; end
      3'd5: begin dy =  2'sd1; dx = -2'sd1; end
      3'd6: begin dy =  2'sd1; dx =  2'sd0; end
      default: begin dy = 2'sd1; dx = 2'sd1; end
    endcase
    ring_up = (RW+1)'(oring_r) + (RW+1)'(d_r);
    ring_dn = (RW+1)'(oring_r) + (RW+1)'(RING) - (RW+1)'(d_r);
    valid_n = 1'b1;
    ring_c = oring_r;
    nx = ocol_r;
    if (!first_r) begin
      if (dy < 0) begin
        if (orow_r < HW'(d_r)) valid_n = 1'b0;
        ring_c = (ring_dn >= (RW+1)'(RING)) ? RW'(ring_dn - (RW+1)'(RING)) : RW'(ring_dn);
      end else if (dy > 0) begin
        if ((HW+1)'(orow_r) + (HW+1)'(d_r) >= (HW+1)'(h_eff)) valid_n = 1'b0;
        ring_c = (ring_up >= (RW+1)'(RING)) ? RW'(ring_up - (RW+1)'(RING)) : RW'(ring_up);
      end
      if (dx < 0) begin
        if (ocol_r < (CW+1)'(d_r)) valid_n = 1'b0;
        nx = ocol_r - (CW+1)'(d_r);
      end else if (dx > 0) begin
        if ((CW+2)'(ocol_r) + (CW+2)'(d_r) >= (CW+2)'(w_eff)) valid_n = 1'b0;
        nx = ocol_r + (CW+1)'(d_r);
      end
    end
  end

  logic [RW-1:0] iring_r;
  always_comb begin
    raddr = AW'(ring_c) * AW'(MAX_WIDTH) + AW'(nx[CW-1:0]);
    waddr = AW'(iring_r) * AW'(MAX_WIDTH) + AW'(icol_r[CW-1:0]);
  end

  snb_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata({in_data.blue_in, in_data.green_in,
    in_data.red_in}), .raddr(raddr), .rdata(rdata));

  logic acc_r;
  logic walk_last;
  assign walk_last = first_r ? (r_eff == '0) : ((k_r == 3'd7) && (d_r == r_eff));

  // dividers
  logic div_start;
  logic done_r, done_g, done_b;
  logic [7:0] q_r, q_g, q_b;
  snb_div u_div_r (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(16'(sr_r)),
    .divisor(10'(cnt_r)), .done(done_r), .quotient(q_r));
  snb_div u_div_g (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(16'(sg_r)),
    .divisor(10'(cnt_r)), .done(done_g), .quotient(q_g));
  snb_div u_div_b (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(16'(sb_r)),
    .divisor(10'(cnt_r)), .done(done_b), .quotient(q_b));

  logic accept_in, cfg_wr, wrap_out, cfg_known;
  assign accept_in = in_valid && !in_stall;
  assign cfg_ready = (st_r == ST_IDLE) && !out_valid;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // a pending config write keeps the input off for that cycle
  assign in_stall  = (st_r != ST_IDLE) || out_valid || cfg_valid;
  assign we = accept_in && (irow_r < h_eff) && !in_data.kind;
  assign wrap_out = (ocol_r + 1'b1 >= w_eff) && (orow_r + 1'b1 >= h_eff);
  assign cfg_known = (cfg_index == CFG_RADIUS) || (cfg_index == CFG_WIDTH) ||
                     (cfg_index == CFG_HEIGHT);

  always_comb begin
    st_nxt = st_r;
    div_start = 1'b0;
    unique case (st_r)
      ST_IDLE:  if (accept_in) st_nxt = ST_CHK;
      ST_CHK:   st_nxt = ready_out ? ST_ADDR : ST_IDLE;
      ST_ADDR:  if (walk_last) st_nxt = ST_ACC;
      // last sample lands in the sums here
      ST_ACC:   st_nxt = ST_START;
      ST_START: begin st_nxt = ST_DIV; div_start = 1'b1; end
      ST_DIV:   if (done_r) st_nxt = ST_OUT;
      ST_OUT:   st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rad_r <= 4'd1;
      wid_r <= 11'd640;
      hgt_r <= 13'd480;
      icol_r <= '0; irow_r <= '0; ocol_r <= '0; orow_r <= '0;
      iring_r <= '0;
      oring_r <= '0;
      out_valid <= 1'b0;
      acc_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      acc_r <= (st_r == ST_ADDR) && valid_n;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_RADIUS: rad_r <= cfg_data[3:0];
          CFG_WIDTH:  wid_r <= cfg_data[10:0];
          CFG_HEIGHT: hgt_r <= cfg_data;
          default: ;
        endcase
        if (cfg_known) begin
          icol_r <= '0; irow_r <= '0; ocol_r <= '0; orow_r <= '0; iring_r <= '0;
          oring_r <= '0;
        end
      end
      if (we) begin
        if (icol_r + 1'b1 >= w_eff) begin
          icol_r <= '0;
          irow_r <= irow_r + 1'b1;
          iring_r <= (iring_r == RW'(RING - 1)) ? '0 : iring_r + 1'b1;
        end else begin
          icol_r <= icol_r + 1'b1;
        end
      end
      if (st_r == ST_OUT) begin
        out_valid <= 1'b1;
        if (wrap_out) begin
          icol_r <= '0; irow_r <= '0; ocol_r <= '0; orow_r <= '0; iring_r <= '0;
          oring_r <= '0;
        end else if (ocol_r + 1'b1 >= w_eff) begin
          ocol_r <= '0;
          orow_r <= orow_r + 1'b1;
          oring_r <= (oring_r == RW'(RING - 1)) ? '0 : oring_r + 1'b1;
        end else begin
          ocol_r <= ocol_r + 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_w;
    if (st_r == ST_CHK) begin
      first_r <= 1'b1; d_r <= RADW'(1); k_r <= 3'd0;
      sr_r <= '0; sg_r <= '0; sb_r <= '0; cnt_r <= '0;
    end else if (st_r == ST_ADDR) begin
      if (first_r) first_r <= 1'b0;
      else if (k_r == 3'd7) begin k_r <= 3'd0; d_r <= d_r + 1'b1; end
      else k_r <= k_r + 1'b1;
    end
    if (acc_r) begin
      sr_r <= sr_r + SW'(rdata[7:0]);
      sg_r <= sg_r + SW'(rdata[15:8]);
      sb_r <= sb_r + SW'(rdata[23:16]);
      cnt_r <= cnt_r + 1'b1;
    end
    if (done_r) begin
      res_r.red_out <= q_r; res_r.green_out <= q_g; res_r.blue_out <= q_b;
    end
    if (st_r == ST_OUT) begin
      res_r.frame_end <= wrap_out;
    end
  end

  assign out_data = res_r;

  `SNB_ASSERT_IMP(a_no_accept_busy, st_r != ST_IDLE, !accept_in, "item accepted while busy")
  `SNB_ASSERT_NXT(a_out_after_st, st_r == ST_OUT, out_valid, "result not presented")
  `SNB_ASSERT_IMP(a_div_lockstep, done_r, done_g && done_b, "dividers out of step")
  `SNB_ASSERT_IMP(a_cfg_idle, cfg_wr, st_r == ST_IDLE && !out_valid, "config while busy")
endmodule
